// ===== hdl/sctadd_pkg.sv =====
// shared widths, defaults and status codes for the saturating count table add
// no dependencies
package sctadd_pkg;

  localparam int GRP_W  = 3;
  localparam int KEY_W  = 16;
  localparam int AMT_W  = 16;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 6;
  localparam int NEWC_W = 10;

  localparam int CAP_W        = 7;
  localparam int NUM_CAP_REGS = 8;
  localparam int CFG_IDX_W    = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam int SLOTS_DEF     = 64;
  localparam int MAX_COUNT_DEF = 999;
  localparam int GROUPS_DEF    = 8;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_MERGE  = 2'd0;
  localparam status_t ST_INSERT = 2'd1;
  localparam status_t ST_REJECT = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

endpackage

// ===== hdl/sctadd_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module sctadd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sctadd_cfg.sv =====
// capacity registers and the usable slot count of a selected group
// depends on sctadd_pkg
module sctadd_cfg #(
  parameter int SLOTS  = sctadd_pkg::SLOTS_DEF,
  parameter int GROUPS = sctadd_pkg::GROUPS_DEF,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [sctadd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sctadd_pkg::CAP_W-1:0]     cfg_wdata,
  input  logic [sctadd_pkg::GRP_W-1:0]     grp,
  output logic [CW-1:0]                   cap_eff
);
  import sctadd_pkg::*;

  logic [CAP_W-1:0] cap_r [NUM_CAP_REGS];
  logic [CAP_W-1:0] capv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CAP_REGS; i++) begin
        cap_r[i] <= CAP_RESET;
      end
    end else if (cfg_valid && (int'(cfg_index) < NUM_CAP_REGS)) begin
      cap_r[cfg_index[GRP_W-1:0]] <= cfg_wdata;
    end
  end

  always_comb begin
    capv = (int'(grp) < GROUPS) ? cap_r[grp] : '0;
    if (int'(capv) > SLOTS) begin
      cap_eff = CW'(SLOTS);
    end else begin
      cap_eff = CW'(capv);
    end
  end

endmodule

// ===== hdl/saturating_count_table_add.sv =====
// Each request scans the slots of its group one memory read per cycle, stopping at the first
// slot that holds the key; at most cap slots are read (cap = usable slots of the group, at
// most SLOTS), through the single read port of the slot memory. Zero key or amount and
// empty groups skip the scan. After reset the block clears the slot memory one entry per
// cycle, all GROUPS * SLOTS entries (512 by default), and accepts no request meanwhile;
// configuration writes are always taken. One request is in flight at a time; a finished
// result waits in the output register while the next request is accepted.
// top level: depends on sctadd_pkg, sctadd_cfg, sctadd_ram
module saturating_count_table_add #(
  parameter int SLOTS     = sctadd_pkg::SLOTS_DEF,
  parameter int MAX_COUNT = sctadd_pkg::MAX_COUNT_DEF,
  parameter int GROUPS    = sctadd_pkg::GROUPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sctadd_pkg::GRP_W-1:0]     in_group_sel,
  input  logic [sctadd_pkg::KEY_W-1:0]     in_key_id,
  input  logic [sctadd_pkg::AMT_W-1:0]     in_amount,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sctadd_pkg::STAT_W-1:0]    out_status,
  output logic [sctadd_pkg::SLOT_W-1:0]    out_slot_used,
  output logic [sctadd_pkg::NEWC_W-1:0]    out_new_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sctadd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sctadd_pkg::CAP_W-1:0]     cfg_wdata
);
  import sctadd_pkg::*;

  localparam int DEPTH = GROUPS * SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int CNTW  = $clog2(MAX_COUNT + 1);
  localparam int SUMW  = ((CNTW > AMT_W) ? CNTW : AMT_W) + 1;
  localparam int SXW   = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int NXW   = (CNTW > NEWC_W) ? CNTW : NEWC_W;
  localparam int MW    = KEY_W + CNTW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [CW-1:0]    cap_r, cap_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [AMT_W-1:0] amt_r, amt_nxt;
  logic [CW-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]    chk_idx_r, chk_idx_nxt;
  logic             have_free_r, have_free_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;
  logic             merge_r, merge_nxt;
  logic [IW-1:0]    hit_idx_r, hit_idx_nxt;
  logic [CNTW-1:0]  hit_cnt_r, hit_cnt_nxt;
  status_t          res_stat_r, res_stat_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [NEWC_W-1:0] res_cnt_r, res_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_stat_r, out_stat_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [NEWC_W-1:0] out_cnt_r, out_cnt_nxt;

  logic [CW-1:0]    cap_eff;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [MW-1:0]    mem_wdata, mem_rdata;
  logic [KEY_W-1:0] rd_key;
  logic [CNTW-1:0]  rd_cnt;
  logic             rd_empty, rd_hit;
  logic [IW-1:0]    wr_idx;
  logic [SUMW-1:0]  sum;
  logic [CNTW-1:0]  total;
  logic [SXW-1:0]   slot_x;
  logic [NXW-1:0]   cnt_x;
  logic             accept, out_free;

  sctadd_cfg #(
    .SLOTS  (SLOTS),
    .GROUPS (GROUPS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .grp       (in_group_sel),
    .cap_eff   (cap_eff)
  );

  sctadd_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_stat_r;
  assign out_slot_used = out_slot_r;
  assign out_new_count = out_cnt_r;

  assign rd_key   = mem_rdata[MW-1:CNTW];
  assign rd_cnt   = mem_rdata[CNTW-1:0];
  assign rd_empty = (rd_key == '0) || (rd_cnt == '0);
  assign rd_hit   = chk_vld_r && !rd_empty && (rd_key == key_r);

  assign mem_raddr = base_r + AW'(rd_cnt_r[IW-1:0]);

  // write side: merge or insert result
  always_comb begin
    wr_idx = merge_r ? hit_idx_r : free_idx_r;
    sum    = SUMW'(amt_r) + (merge_r ? SUMW'(hit_cnt_r) : '0);
    total  = (sum > SUMW'(MAX_COUNT)) ? CNTW'(MAX_COUNT) : CNTW'(sum);
    slot_x = SXW'(wr_idx);
    cnt_x  = NXW'(total);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == S_WR) begin
      mem_we    = 1'b1;
      mem_waddr = base_r + AW'(wr_idx);
      mem_wdata = {key_r, total};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    base_nxt      = base_r;
    cap_nxt       = cap_r;
    key_nxt       = key_r;
    amt_nxt       = amt_r;
    rd_cnt_nxt    = rd_cnt_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    have_free_nxt = have_free_r;
    free_idx_nxt  = free_idx_r;
    merge_nxt     = merge_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    res_stat_nxt  = res_stat_r;
    res_slot_nxt  = res_slot_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_stat_nxt  = out_stat_r;
    out_slot_nxt  = out_slot_r;
    out_cnt_nxt   = out_cnt_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          key_nxt       = in_key_id;
          amt_nxt       = in_amount;
          cap_nxt       = cap_eff;
          base_nxt      = AW'(int'(in_group_sel) * SLOTS);
          rd_cnt_nxt    = '0;
          have_free_nxt = 1'b0;
          merge_nxt     = 1'b0;
          res_slot_nxt  = '0;
          res_cnt_nxt   = '0;
          if (in_key_id == '0 || in_amount == '0) begin
            res_stat_nxt = ST_REJECT;
            state_nxt    = S_RESP;
          end else if (cap_eff == '0) begin
            res_stat_nxt = ST_FULL;
            state_nxt    = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (chk_vld_r && rd_empty && !have_free_r) begin
          have_free_nxt = 1'b1;
          free_idx_nxt  = chk_idx_r;
        end
        if (rd_hit) begin
          merge_nxt   = 1'b1;
          hit_idx_nxt = chk_idx_r;
          hit_cnt_nxt = rd_cnt;
          state_nxt   = S_WR;
        end else if (rd_cnt_r < cap_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_cnt_r[IW-1:0];
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
        end else if (!chk_vld_r) begin
          if (have_free_r) begin
            state_nxt = S_WR;
          end else begin
            res_stat_nxt = ST_FULL;
            state_nxt    = S_RESP;
          end
        end
      end
      S_WR: begin
        res_stat_nxt = merge_r ? ST_MERGE : ST_INSERT;
        res_slot_nxt = slot_x[SLOT_W-1:0];
        res_cnt_nxt  = cnt_x[NEWC_W-1:0];
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_slot_nxt  = res_slot_r;
          out_cnt_nxt   = res_cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    cap_r       <= cap_nxt;
    key_r       <= key_nxt;
    amt_r       <= amt_nxt;
    rd_cnt_r    <= rd_cnt_nxt;
    chk_idx_r   <= chk_idx_nxt;
    have_free_r <= have_free_nxt;
    free_idx_r  <= free_idx_nxt;
    merge_r     <= merge_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    res_stat_r  <= res_stat_nxt;
    res_slot_r  <= res_slot_nxt;
    res_cnt_r   <= res_cnt_nxt;
    out_stat_r  <= out_stat_nxt;
    out_slot_r  <= out_slot_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

endmodule

// ===== hdl/sctadd_chk.sv =====
// port-level checker for the saturating count table add, bound to the top level
// depends on sctadd_pkg and saturating_count_table_add
module sctadd_chk #(
  parameter int MAX_COUNT = sctadd_pkg::MAX_COUNT_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sctadd_pkg::STAT_W-1:0] out_status,
  input logic [sctadd_pkg::SLOT_W-1:0] out_slot_used,
  input logic [sctadd_pkg::NEWC_W-1:0] out_new_count
);
  import sctadd_pkg::*;

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_slot_used) && $stable(out_new_count))
    else $error("stalled result changed");

  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REJECT || out_status == ST_FULL)
      |-> out_slot_used == '0 && out_new_count == '0)
    else $error("reject or full result carries a slot or count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MERGE || out_status == ST_INSERT)
      |-> (MAX_COUNT > 1023) || (out_new_count != '0 && int'(out_new_count) <= MAX_COUNT))
    else $error("stored count out of range");

endmodule

bind saturating_count_table_add sctadd_chk #(
  .MAX_COUNT (MAX_COUNT)
) u_sctadd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_slot_used (out_slot_used),
  .out_new_count (out_new_count)
);
